>>> rtl/wsp_pkg.sv
// Package with shared constants for the world-to-screen projection block.
package wsp_pkg;

	// Default fixed-point format of points, coefficients and screen values.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed port widths, the half-window width and the coefficient register count.
	localparam int POINT_W    = 32;
	localparam int COEF_W     = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int WIN_W      = 14;
	localparam int HALF_W     = WIN_W - 1;
	localparam int NUM_COEF   = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X_POS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X_ZO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_POS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_ZO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_W_POS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_W_ZO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd7;

	// Reset values of the window size.
	localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 14'd640;
	localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 14'd480;

endpackage

>>> rtl/world_to_screen_projection.sv
// World-to-screen perspective projection: matrix rows, visibility test, divider and pixel mapping.
//
// Usage: a point (point_x, point_y, point_z, signed fixed point) is transferred on the
// input channel when in_valid is high and in_stall is low. One result (visible,
// screen_x, screen_y) is transferred on the output channel when out_valid is high and
// out_stall is low. Results leave in the order the points came in.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes one register per cycle;
// registers 0 to 5 hold coefficient pairs, 6 and 7 the window width and height.
// Write them only while no point is in flight.
// Throughput: one point per cycle while the output is not stalled; the datapath is fully
// pipelined, and in_stall holds new points while the skid register is full. The divider
// computes one quotient bit per stage, with the X and Y lanes running side by side.
// Reset: arst_n clears all valid bits, the coefficients to zero and the window to
// 640 by 480.
// Stalls: a skid register behind the output register catches the one result that is
// still moving when the receiver stalls; in_stall is registered and rises only once
// that skid register is full, so no transfer is lost or repeated.
module world_to_screen_projection #(
	parameter int FRAC_BITS  = wsp_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = wsp_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wsp_pkg::POINT_W-1:0]  point_x,
	input  logic signed [wsp_pkg::POINT_W-1:0]  point_y,
	input  logic signed [wsp_pkg::POINT_W-1:0]  point_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                visible,
	output logic signed [wsp_pkg::POINT_W-1:0]  screen_x,
	output logic signed [wsp_pkg::POINT_W-1:0]  screen_y
);

	localparam int F    = FRAC_BITS;
	localparam int DW   = DATA_WIDTH;
	localparam int PRW  = wsp_pkg::POINT_W + wsp_pkg::COEF_W;
	localparam int SHW  = PRW - F;
	localparam int CW   = SHW + 2;
	localparam int NW   = CW + F;
	localparam int Q    = DW - 1;
	localparam int MW   = DW + wsp_pkg::WIN_W + 1;
	localparam int SW   = MW + 1;
	localparam logic signed [CW-1:0] THR = CW'(((64'd1 << F) + 64'd9) / 64'd10);
	localparam logic signed [DW-1:0] LIM_HI = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] LIM_LO = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [SW-1:0] SAT_HI = SW'(LIM_HI);
	localparam logic signed [SW-1:0] SAT_LO = SW'(LIM_LO);

	// Configuration registers.
	logic [wsp_pkg::CFG_DATA_W-1:0] coef_q [wsp_pkg::NUM_COEF];
	logic [wsp_pkg::WIN_W-1:0]      win_w_q;
	logic [wsp_pkg::WIN_W-1:0]      win_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsp_pkg::NUM_COEF; i++) coef_q[i] <= '0;
			win_w_q <= wsp_pkg::WIN_WIDTH_RST;
			win_h_q <= wsp_pkg::WIN_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wsp_pkg::REG_COEF_X_POS: coef_q[0] <= cfg_data;
				wsp_pkg::REG_COEF_X_ZO:  coef_q[1] <= cfg_data;
				wsp_pkg::REG_COEF_Y_POS: coef_q[2] <= cfg_data;
				wsp_pkg::REG_COEF_Y_ZO:  coef_q[3] <= cfg_data;
				wsp_pkg::REG_COEF_W_POS: coef_q[4] <= cfg_data;
				wsp_pkg::REG_COEF_W_ZO:  coef_q[5] <= cfg_data;
				wsp_pkg::REG_WIN_WIDTH:  win_w_q <= cfg_data[wsp_pkg::WIN_W-1:0];
				wsp_pkg::REG_WIN_HEIGHT: win_h_q <= cfg_data[wsp_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances unless the skid register is occupied.
	logic en;
	logic skv_q;
	assign en       = !skv_q;
	assign in_stall = skv_q;

	// Stage 1: nine products, three per clip row.
	logic               v_s1;
	logic signed [PRW-1:0] prod_s1 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= point_x * $signed(coef_q[2*r][31:0]);
				prod_s1[3*r+1] <= point_y * $signed(coef_q[2*r][63:32]);
				prod_s1[3*r+2] <= point_z * $signed(coef_q[2*r+1][31:0]);
			end
		end
	end

	// Stage 2: floor each product to the output format and add the offset.
	logic                 v_s2;
	logic signed [CW-1:0] clip_s2 [3];
	logic signed [PRW-1:0] sh [9];
	logic signed [CW-1:0]  clip_d [3];

	always_comb begin
		for (int k = 0; k < 9; k++) sh[k] = prod_s1[k] >>> F;
		for (int r = 0; r < 3; r++) begin
			clip_d[r] = CW'(sh[3*r]) + CW'(sh[3*r+1]) + CW'(sh[3*r+2])
			          + CW'($signed(coef_q[2*r+1][63:32]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) for (int r = 0; r < 3; r++) clip_s2[r] <= clip_d[r];
	end

	// Stage 3: visibility test and magnitudes of X and Y.
	logic          v_s3, vis_s3, negx_s3, negy_s3;
	logic [CW-1:0] magx_s3, magy_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3  <= clip_s2[2] >= THR;
			negx_s3 <= clip_s2[0][CW-1];
			negy_s3 <= clip_s2[1][CW-1];
			magx_s3 <= clip_s2[0][CW-1] ? CW'(-clip_s2[0]) : CW'(clip_s2[0]);
			magy_s3 <= clip_s2[1][CW-1] ? CW'(-clip_s2[1]) : CW'(clip_s2[1]);
			den_s3  <= clip_s2[2];
		end
	end

	// Divider pipeline: entry 0 is loaded by stage 4, each later entry adds one bit.
	logic          v_sd    [0:Q];
	logic          vis_sd  [0:Q];
	logic          negx_sd [0:Q];
	logic          negy_sd [0:Q];
	logic          ovfx_sd [0:Q];
	logic          ovfy_sd [0:Q];
	logic [CW-1:0] den_sd  [0:Q];
	logic [CW-1:0] remx_sd [0:Q];
	logic [CW-1:0] remy_sd [0:Q];
	logic [Q-1:0]  nlx_sd  [0:Q];
	logic [Q-1:0]  nly_sd  [0:Q];
	logic [Q-1:0]  qx_sd   [0:Q];
	logic [Q-1:0]  qy_sd   [0:Q];

	// Stage 4: scaled dividends, overflow checks and initial remainders.
	logic [NW-1:0] nfx, nfy, hix, hiy;
	always_comb begin
		nfx = {magx_s3, {F{1'b0}}};
		nfy = {magy_s3, {F{1'b0}}};
		hix = nfx >> Q;
		hiy = nfy >> Q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sd[0] <= 1'b0;
		else if (en) v_sd[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_sd[0]  <= vis_s3;
			negx_sd[0] <= negx_s3;
			negy_sd[0] <= negy_s3;
			ovfx_sd[0] <= hix >= NW'(den_s3);
			ovfy_sd[0] <= hiy >= NW'(den_s3);
			den_sd[0]  <= den_s3;
			remx_sd[0] <= hix[CW-1:0];
			remy_sd[0] <= hiy[CW-1:0];
			nlx_sd[0]  <= nfx[Q-1:0];
			nly_sd[0]  <= nfy[Q-1:0];
			qx_sd[0]   <= '0;
			qy_sd[0]   <= '0;
		end
	end

	// One restoring division step per stage for each lane.
	for (genvar k = 1; k <= Q; k++) begin : g_div
		logic [CW:0] tx, ty;
		logic        bx, by;
		always_comb begin
			tx = {remx_sd[k-1], nlx_sd[k-1][Q-1]};
			ty = {remy_sd[k-1], nly_sd[k-1][Q-1]};
			bx = tx >= {1'b0, den_sd[k-1]};
			by = ty >= {1'b0, den_sd[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sd[k] <= 1'b0;
			else if (en) v_sd[k] <= v_sd[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vis_sd[k]  <= vis_sd[k-1];
				negx_sd[k] <= negx_sd[k-1];
				negy_sd[k] <= negy_sd[k-1];
				ovfx_sd[k] <= ovfx_sd[k-1];
				ovfy_sd[k] <= ovfy_sd[k-1];
				den_sd[k]  <= den_sd[k-1];
				remx_sd[k] <= bx ? CW'(tx - {1'b0, den_sd[k-1]}) : tx[CW-1:0];
				remy_sd[k] <= by ? CW'(ty - {1'b0, den_sd[k-1]}) : ty[CW-1:0];
				nlx_sd[k]  <= nlx_sd[k-1] << 1;
				nly_sd[k]  <= nly_sd[k-1] << 1;
				qx_sd[k]   <= {qx_sd[k-1][Q-2:0], bx};
				qy_sd[k]   <= {qy_sd[k-1][Q-2:0], by};
			end
		end
	end

	// Stage 5: signed NDC values with saturation on overflow.
	logic                 v_s5, vis_s5;
	logic signed [DW-1:0] ndcx_s5, ndcy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_sd[Q];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s5 <= vis_sd[Q];
			if (ovfx_sd[Q]) ndcx_s5 <= negx_sd[Q] ? LIM_LO : LIM_HI;
			else ndcx_s5 <= negx_sd[Q] ? -DW'(qx_sd[Q]) : DW'(qx_sd[Q]);
			if (ovfy_sd[Q]) ndcy_s5 <= negy_sd[Q] ? LIM_LO : LIM_HI;
			else ndcy_s5 <= negy_sd[Q] ? -DW'(qy_sd[Q]) : DW'(qy_sd[Q]);
		end
	end

	// Stage 6: scale X by the half width plus one and Y by one minus the half height, inverting the Y axis.
	logic [wsp_pkg::HALF_W-1:0] hw, hh;
	logic signed [wsp_pkg::WIN_W:0] kx, ky;
	logic                 v_s6, vis_s6;
	logic signed [MW-1:0] mx_s6, my_s6;

	always_comb begin
		hw = win_w_q[wsp_pkg::WIN_W-1:1];
		hh = win_h_q[wsp_pkg::WIN_W-1:1];
		kx = $signed({2'b00, hw}) + 15'sd1;
		ky = 15'sd1 - $signed({2'b00, hh});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s6 <= vis_s5;
			mx_s6  <= MW'(kx * ndcx_s5);
			my_s6  <= MW'(ky * ndcy_s5);
		end
	end

	// Stage 7: add the window center, saturate and clear hidden points.
	logic signed [SW-1:0] sumx, sumy, satx, saty;
	logic                 v_s7, vis_s7;
	logic signed [wsp_pkg::POINT_W-1:0] sx_s7, sy_s7;

	always_comb begin
		sumx = SW'(mx_s6) + $signed(SW'({hw, {F{1'b0}}}));
		sumy = SW'(my_s6) + $signed(SW'({hh, {F{1'b0}}}));
		satx = (sumx > SAT_HI) ? SAT_HI : ((sumx < SAT_LO) ? SAT_LO : sumx);
		saty = (sumy > SAT_HI) ? SAT_HI : ((sumy < SAT_LO) ? SAT_LO : sumy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s7 <= vis_s6;
			sx_s7  <= vis_s6 ? satx[wsp_pkg::POINT_W-1:0] : '0;
			sy_s7  <= vis_s6 ? saty[wsp_pkg::POINT_W-1:0] : '0;
		end
	end

	// Output register and skid register.
	logic take, push;
	logic vis_q, skvis_q;
	logic signed [wsp_pkg::POINT_W-1:0] sx_q, sy_q, sksx_q, sksy_q;
	logic ov_q;

	assign take = ov_q && !out_stall;
	assign push = v_s7 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			skv_q <= 1'b0;
		end else if (skv_q) begin
			if (take) skv_q <= 1'b0;
		end else if (push) begin
			if (ov_q && !take) skv_q <= 1'b1;
			else ov_q <= 1'b1;
		end else if (take) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skv_q) begin
			if (take) begin
				vis_q <= skvis_q;
				sx_q  <= sksx_q;
				sy_q  <= sksy_q;
			end
		end else if (push) begin
			if (ov_q && !take) begin
				skvis_q <= vis_s7;
				sksx_q  <= sx_s7;
				sksy_q  <= sy_s7;
			end else begin
				vis_q <= vis_s7;
				sx_q  <= sx_s7;
				sy_q  <= sy_s7;
			end
		end
	end

	assign out_valid = ov_q;
	assign visible   = vis_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;

endmodule
